// ----- src/aegs_pkg.sv -----
// Shared types, constants and elaboration-time tables for the auto exposure gain stepper.
// No dependencies; every other file but aegs_if refers to this package by scoped names.
package aegs_pkg;

   localparam int HIST = 5;
   localparam int HIST_W = (HIST > 1) ? $clog2(HIST) : 1;
   localparam int WSUM = HIST * (HIST + 1) / 2;
   localparam int ACC_W = 16 + $clog2(WSUM + 1);

   // rounded average by reciprocal multiply; the extra shift bits keep the floor exact
   localparam int AVG_SHIFT = ACC_W + $clog2(WSUM) + 1;
   localparam logic [AVG_SHIFT-1:0] AVG_RECIP =
      AVG_SHIFT'(((64'd1 << AVG_SHIFT) + 64'(WSUM) - 64'd1) / 64'(WSUM));

   localparam logic [15:0] RING_RESET = 16'd32768;
   localparam logic signed [31:0] LEVEL_RESET = 32'sd0;
   localparam logic [12:0] GAIN_RESET = 13'd256;
   localparam logic [6:0] BRIGHT_RESET = 7'd50;
   localparam logic [27:0] SHUT_RESET = 28'd1000000;

   localparam logic [12:0] GAIN_MIN = 13'd256;
   localparam logic [13:0] GAIN_SLEW = 14'd512;
   localparam logic [15:0] CHANGE_MAX = 16'hFFFF;
   localparam logic [19:0] US_PER_SEC = 20'd1000000;
   localparam logic signed [32:0] EXP_BIAS = 33'sd22;

   typedef enum logic [2:0] {
      REG_TARGET_MEAN    = 3'd0,
      REG_MEAN_TOLERANCE = 3'd1,
      REG_FAST_FORWARD   = 3'd2,
      REG_SHUTTER_STEPS  = 3'd3,
      REG_TRIM_ON        = 3'd4,
      REG_MAX_EXPOSURE   = 3'd5,
      REG_MAX_GAIN       = 3'd6,
      REG_MAX_BRIGHTNESS = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0] target_mean;
      logic [15:0] mean_tolerance;
      logic [15:0] fast_forward;
      logic [7:0]  shutter_steps;
      logic        trim_on;
      logic [27:0] max_exposure_us;
      logic [12:0] max_gain;
      logic [6:0]  max_brightness;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [27:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
      logic [27:0] remainder;
   } div_rsp_type;

   typedef enum logic [14:0] {
      ST_IDLE  = 15'b000000000000001,
      ST_SUM   = 15'b000000000000010,
      ST_W_AVG = 15'b000000000000100,
      ST_DIFF  = 15'b000000000001000,
      ST_MUL2  = 15'b000000000010000,
      ST_MUL3  = 15'b000000000100000,
      ST_UPD   = 15'b000000001000000,
      ST_W_LVL = 15'b000000010000000,
      ST_W_FQ  = 15'b000000100000000,
      ST_EXP   = 15'b000001000000000,
      ST_XMUL  = 15'b000010000000000,
      ST_SHIFT = 15'b000100000000000,
      ST_W_Q   = 15'b001000000000000,
      ST_W_T   = 15'b010000000000000,
      ST_SHUT  = 15'b100000000000000
   } state_type;

   typedef logic [15:0][31:0] root_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem = v;
      res = 64'd0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // c[k] = 2^(2^-(k+1)) in Q.30, each root taken from the truncated previous one
   function automatic root_tab_type build_roots();
      root_tab_type tab;
      logic [63:0] c;
      c = isqrt64(64'd1 << 61);
      for (int k = 0; k < 16; k++) begin
         tab[k] = c[31:0];
         c = isqrt64(c << 30);
      end
      return tab;
   endfunction

   localparam root_tab_type EXP2_ROOTS = build_roots();

endpackage

// ----- src/aegs_if.sv -----
// Handshake channel interfaces: frame input, result output and register write port.
// Depends on nothing.
interface aegs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] frame_mean;
   modport source (output valid, output frame_mean, input ready);
   modport sink (input valid, input frame_mean, output ready);
endinterface

interface aegs_rsp_if;
   logic               valid;
   logic               ready;
   logic [27:0]        shutter_us;
   logic [12:0]        gain_q88;
   logic [6:0]         brightness_now;
   logic signed [31:0] level_now;
   logic [15:0]        smoothed_mean;
   modport source (output valid, output shutter_us, output gain_q88, output brightness_now,
                   output level_now, output smoothed_mean, input ready);
   modport sink (input valid, input shutter_us, input gain_q88, input brightness_now,
                 input level_now, input smoothed_mean, output ready);
endinterface

interface aegs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [27:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/auto_exposure_gain_stepper_core.sv -----
// Auto exposure controller top level: sequencer, datapath and output register.
// Depends on aegs_pkg, aegs_if, aegs_csr and aegs_div.
//
// One frame brightness in, one exposure result out. A frame passes through the weighted
// history sum, one reciprocal multiply for the average, four runs of the shared bit-serial
// divider (level split, exponent fraction, target gain, shutter time), a fractional exp2
// on the multiplier that takes one fraction bit per step, and the register steps between
// them. req ready is high only while the sequencer is idle; a finished result sits in the
// output register, and the next frame may be accepted while it waits.
module auto_exposure_gain_stepper_core (
   input  logic         clock,
   input  logic         reset,
   aegs_req_if.sink     req_chan,
   aegs_rsp_if.source   rsp_chan,
   aegs_csr_if.sink     csr_chan
);
   localparam int HW = aegs_pkg::HIST_W;
   localparam int AW = aegs_pkg::ACC_W;
   localparam int PW = AW + 1 + aegs_pkg::AVG_SHIFT;

   aegs_pkg::cfg_type     cfg;
   aegs_pkg::div_req_type div_req;
   aegs_pkg::div_rsp_type div_rsp;

   aegs_csr u_csr (.clock(clock), .reset(reset), .csr(csr_chan), .cfg(cfg));
   aegs_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   aegs_pkg::state_type state_ff, state_in;
   logic [15:0]        ring_ff [aegs_pkg::HIST];
   logic [15:0]        ring_in [aegs_pkg::HIST];
   logic [HW-1:0]      ptr_ff, ptr_in;
   logic [HW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic [15:0]        avg_ff, avg_in;
   logic               fast_ff, fast_in;
   logic               low_ff, low_in;
   logic               high_ff, high_in;
   logic [39:0]        prod_ff, prod_in;
   logic [63:0]        sq_ff, sq_in;
   logic [15:0]        s2_ff, s2_in;
   logic signed [31:0] level_ff, level_in;
   logic               neg_ff, neg_in;
   logic signed [32:0] n_ff, n_in;
   logic [15:0]        fq_ff, fq_in;
   logic [3:0]         k_ff, k_in;
   logic [31:0]        p_ff, p_in;
   logic [63:0]        y_ff, y_in;
   logic [12:0]        gain_ff, gain_in;
   logic [6:0]         bright_ff, bright_in;
   logic [27:0]        shut_ff, shut_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [27:0]        rsp_shut_ff, rsp_shut_in;
   logic [12:0]        rsp_gain_ff, rsp_gain_in;
   logic [6:0]         rsp_bright_ff, rsp_bright_in;
   logic signed [31:0] rsp_level_ff, rsp_level_in;
   logic [15:0]        rsp_avg_ff, rsp_avg_in;

   logic [7:0]         s_eff;
   logic [27:0]        maxexp;
   logic [12:0]        maxg;
   logic               req_take;

   // working values
   logic [HW:0]        sel_sum, sel;
   logic [AW-1:0]      term;
   logic [AW:0]        avg_num;
   logic [PW-1:0]      avg_prod;
   logic [15:0]        diff;
   logic [15:0]        change;
   logic signed [32:0] lvl_ext, plus, minus;
   logic signed [31:0] new_level;
   logic [31:0]        mag;
   logic [31:0]        q0;
   logic [15:0]        rem16, r_val;
   logic [63:0]        ptmp;
   logic [33:0]        sh;
   logic [63:0]        qv;
   logic [12:0]        qc;
   logic [13:0]        gslew;
   logic [63:0]        tv;

   assign s_eff = (cfg.shutter_steps == 8'd0) ? 8'd1 : cfg.shutter_steps;
   assign maxexp = (cfg.max_exposure_us == 28'd0) ? 28'd1 : cfg.max_exposure_us;
   assign maxg = (cfg.max_gain < aegs_pkg::GAIN_MIN) ? aegs_pkg::GAIN_MIN : cfg.max_gain;

   assign req_chan.ready = (state_ff == aegs_pkg::ST_IDLE);
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in = state_ff;
      ring_in = ring_ff;
      ptr_in = ptr_ff;
      idx_in = idx_ff;
      acc_in = acc_ff;
      avg_in = avg_ff;
      fast_in = fast_ff;
      low_in = low_ff;
      high_in = high_ff;
      prod_in = prod_ff;
      sq_in = sq_ff;
      s2_in = s2_ff;
      level_in = level_ff;
      neg_in = neg_ff;
      n_in = n_ff;
      fq_in = fq_ff;
      k_in = k_ff;
      p_in = p_ff;
      y_in = y_ff;
      gain_in = gain_ff;
      bright_in = bright_ff;
      shut_in = shut_ff;
      rsp_shut_in = rsp_shut_ff;
      rsp_gain_in = rsp_gain_ff;
      rsp_bright_in = rsp_bright_ff;
      rsp_level_in = rsp_level_ff;
      rsp_avg_in = rsp_avg_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.valid && rsp_chan.ready) rsp_valid_in = 1'b0;

      div_req.start = 1'b0;
      div_req.dividend = 64'd0;
      div_req.divisor = 28'd1;

      sel_sum = {1'b0, ptr_ff} + {1'b0, idx_ff} + (HW+1)'(1);
      sel = (sel_sum >= (HW+1)'(aegs_pkg::HIST)) ? sel_sum - (HW+1)'(aegs_pkg::HIST)
                                                 : sel_sum;
      term = AW'(ring_ff[sel[HW-1:0]]) * (AW'(idx_ff) + AW'(1));
      avg_num = (AW+1)'(acc_ff) + (AW+1)'(aegs_pkg::WSUM / 2);
      avg_prod = PW'(avg_num) * PW'(aegs_pkg::AVG_RECIP);
      diff = (avg_ff >= cfg.target_mean) ? avg_ff - cfg.target_mean
                                         : cfg.target_mean - avg_ff;
      if (!fast_ff) change = 16'd1;
      else if (prod_ff[39:32] != 8'd0) change = aegs_pkg::CHANGE_MAX;
      else if (sq_ff[63:48] == 16'd0) change = 16'd1;
      else change = sq_ff[63:48];
      lvl_ext = {level_ff[31], level_ff};
      plus = lvl_ext + $signed({17'd0, change});
      minus = lvl_ext - $signed({17'd0, change});
      new_level = level_ff;
      mag = 32'd0;
      q0 = div_rsp.quotient[31:0];
      rem16 = div_rsp.remainder[15:0];
      r_val = 16'd0;
      ptmp = 64'(p_ff) * 64'(aegs_pkg::EXP2_ROOTS[k_ff]);
      sh = 34'sd0;
      qv = div_rsp.quotient;
      qc = 13'd0;
      gslew = 14'd0;
      tv = div_rsp.quotient;

      unique case (state_ff)
         aegs_pkg::ST_IDLE: begin
            if (req_take) begin
               ring_in[ptr_ff] = req_chan.frame_mean;
               idx_in = '0;
               acc_in = '0;
               state_in = aegs_pkg::ST_SUM;
            end
         end
         aegs_pkg::ST_SUM: begin
            // oldest entry gets weight 1, the newest gets HIST
            acc_in = acc_ff + term;
            if (idx_ff == HW'(aegs_pkg::HIST - 1)) begin
               ptr_in = (ptr_ff == HW'(aegs_pkg::HIST - 1)) ? '0 : ptr_ff + HW'(1);
               state_in = aegs_pkg::ST_W_AVG;
            end else begin
               idx_in = idx_ff + HW'(1);
            end
         end
         aegs_pkg::ST_W_AVG: begin
            // rounded division by the weight total as a reciprocal multiply
            avg_in = avg_prod[aegs_pkg::AVG_SHIFT +: 16];
            state_in = aegs_pkg::ST_DIFF;
         end
         aegs_pkg::ST_DIFF: begin
            low_in = ({1'b0, avg_ff} + {1'b0, cfg.mean_tolerance}) < {1'b0, cfg.target_mean};
            high_in = {1'b0, avg_ff} > ({1'b0, cfg.target_mean} + {1'b0, cfg.mean_tolerance});
            fast_in = {1'b0, diff} > {cfg.mean_tolerance, 1'b0};
            prod_in = {8'd0, 32'(diff) * 32'(cfg.fast_forward)};
            s2_in = 16'(s_eff) * 16'(s_eff);
            state_in = aegs_pkg::ST_MUL2;
         end
         aegs_pkg::ST_MUL2: begin
            prod_in = 40'(prod_ff[31:0]) * 40'(s_eff);
            state_in = aegs_pkg::ST_MUL3;
         end
         aegs_pkg::ST_MUL3: begin
            sq_in = 64'(prod_ff[31:0]) * 64'(prod_ff[31:0]);
            state_in = aegs_pkg::ST_UPD;
         end
         aegs_pkg::ST_UPD: begin
            if (low_ff) begin
               if (cfg.trim_on && (bright_ff < cfg.max_brightness)) begin
                  bright_in = bright_ff + 7'd1;
               end else if ((gain_ff < maxg) || (shut_ff < maxexp)) begin
                  new_level = (plus[32] != plus[31]) ?
                              (plus[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : plus[31:0];
               end
            end
            if (high_ff) begin
               if (shut_ff <= 28'd1) begin
                  if (cfg.trim_on && (bright_ff != 7'd0)) bright_in = bright_ff - 7'd1;
               end else begin
                  new_level = (minus[32] != minus[31]) ?
                              (minus[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : minus[31:0];
               end
            end
            level_in = new_level;
            neg_in = new_level[31];
            mag = new_level[31] ? 32'd0 - new_level : new_level;
            div_req.start = 1'b1;
            div_req.dividend = {32'd0, mag};
            div_req.divisor = {12'd0, s2_ff};
            state_in = aegs_pkg::ST_W_LVL;
         end
         aegs_pkg::ST_W_LVL: begin
            // floor division: a negative level with a remainder rounds one further down
            if (div_rsp.done) begin
               if (neg_ff) begin
                  n_in = 33'sd0 - $signed({1'b0, q0}) - ((rem16 != 16'd0) ? 33'sd1 : 33'sd0);
                  r_val = (rem16 != 16'd0) ? s2_ff - rem16 : 16'd0;
               end else begin
                  n_in = $signed({1'b0, q0});
                  r_val = rem16;
               end
               div_req.start = 1'b1;
               div_req.dividend = {32'd0, r_val, 16'd0};
               div_req.divisor = {12'd0, s2_ff};
               state_in = aegs_pkg::ST_W_FQ;
            end
         end
         aegs_pkg::ST_W_FQ: begin
            if (div_rsp.done) begin
               fq_in = div_rsp.quotient[15:0];
               p_in = 32'd1 << 30;
               k_in = 4'd0;
               state_in = aegs_pkg::ST_EXP;
            end
         end
         aegs_pkg::ST_EXP: begin
            // step k handles fraction bit of weight 2^-(k+1), MSB first
            if (fq_ff[~k_ff]) p_in = ptmp[61:30];
            if (k_ff == 4'd15) state_in = aegs_pkg::ST_XMUL;
            else k_in = k_ff + 4'd1;
         end
         aegs_pkg::ST_XMUL: begin
            y_in = 64'(p_ff) * 64'(aegs_pkg::US_PER_SEC);
            state_in = aegs_pkg::ST_SHIFT;
         end
         aegs_pkg::ST_SHIFT: begin
            sh = {aegs_pkg::EXP_BIAS[32], aegs_pkg::EXP_BIAS} - {n_ff[32], n_ff};
            if (!n_ff[32] && (n_ff >= aegs_pkg::EXP_BIAS)) y_in = 64'd1 << 62;
            else if (sh[33:6] != 28'd0) y_in = 64'd0;
            else y_in = y_ff >> sh[5:0];
            div_req.start = 1'b1;
            div_req.dividend = y_in;
            div_req.divisor = maxexp;
            state_in = aegs_pkg::ST_W_Q;
         end
         aegs_pkg::ST_W_Q: begin
            if (div_rsp.done) begin
               if (qv < 64'(aegs_pkg::GAIN_MIN)) qc = aegs_pkg::GAIN_MIN;
               else if (qv > 64'(maxg)) qc = maxg;
               else qc = qv[12:0];
               if ({1'b0, qc} > ({1'b0, gain_ff} + aegs_pkg::GAIN_SLEW))
                  gslew = {1'b0, gain_ff} + aegs_pkg::GAIN_SLEW;
               else if (({1'b0, qc} + aegs_pkg::GAIN_SLEW) < {1'b0, gain_ff})
                  gslew = {1'b0, gain_ff} - aegs_pkg::GAIN_SLEW;
               else
                  gslew = {1'b0, qc};
               gain_in = gslew[12:0];
               div_req.start = 1'b1;
               div_req.dividend = y_ff;
               div_req.divisor = (gain_in == 13'd0) ? 28'd1 : 28'(gain_in);
               state_in = aegs_pkg::ST_W_T;
            end
         end
         aegs_pkg::ST_W_T: begin
            if (div_rsp.done) begin
               if (tv > 64'(maxexp)) shut_in = maxexp;
               else if (tv == 64'd0) shut_in = 28'd1;
               else shut_in = tv[27:0];
               state_in = aegs_pkg::ST_SHUT;
            end
         end
         aegs_pkg::ST_SHUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_shut_in = shut_ff;
               rsp_gain_in = gain_ff;
               rsp_bright_in = bright_ff;
               rsp_level_in = level_ff;
               rsp_avg_in = avg_ff;
               state_in = aegs_pkg::ST_IDLE;
            end
         end
         default: state_in = aegs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aegs_pkg::ST_IDLE;
         for (int i = 0; i < aegs_pkg::HIST; i++) ring_ff[i] <= aegs_pkg::RING_RESET;
         ptr_ff <= '0;
         level_ff <= aegs_pkg::LEVEL_RESET;
         gain_ff <= aegs_pkg::GAIN_RESET;
         bright_ff <= aegs_pkg::BRIGHT_RESET;
         shut_ff <= aegs_pkg::SHUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ring_ff <= ring_in;
         ptr_ff <= ptr_in;
         level_ff <= level_in;
         gain_ff <= gain_in;
         bright_ff <= bright_in;
         shut_ff <= shut_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      avg_ff <= avg_in;
      fast_ff <= fast_in;
      low_ff <= low_in;
      high_ff <= high_in;
      prod_ff <= prod_in;
      sq_ff <= sq_in;
      s2_ff <= s2_in;
      neg_ff <= neg_in;
      n_ff <= n_in;
      fq_ff <= fq_in;
      k_ff <= k_in;
      p_ff <= p_in;
      y_ff <= y_in;
      rsp_shut_ff <= rsp_shut_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_bright_ff <= rsp_bright_in;
      rsp_level_ff <= rsp_level_in;
      rsp_avg_ff <= rsp_avg_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.shutter_us = rsp_shut_ff;
   assign rsp_chan.gain_q88 = rsp_gain_ff;
   assign rsp_chan.brightness_now = rsp_bright_ff;
   assign rsp_chan.level_now = rsp_level_ff;
   assign rsp_chan.smoothed_mean = rsp_avg_ff;

   a_div_not_restarted: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider restarted while busy");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff < HW'(aegs_pkg::HIST))
      else $error("ring pointer out of range");

   a_gain_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.gain_q88 >= aegs_pkg::GAIN_MIN))
      else $error("gain result below unity");

   a_shutter_nonzero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> (rsp_chan.shutter_us != 28'd0) && $past(state_ff == aegs_pkg::ST_SHUT))
      else $error("result raised without shutter stage");
endmodule

// ----- src/aegs_csr.sv -----
// Configuration register file, written through the csr channel.
// Depends on aegs_pkg and aegs_csr_if.
module aegs_csr (
   input  logic               clock,
   input  logic               reset,
   aegs_csr_if.sink           csr,
   output aegs_pkg::cfg_type  cfg
);
   aegs_pkg::cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (aegs_pkg::csr_index_type'(csr.index))
            aegs_pkg::REG_TARGET_MEAN:    cfg_in.target_mean = csr.data[15:0];
            aegs_pkg::REG_MEAN_TOLERANCE: cfg_in.mean_tolerance = csr.data[15:0];
            aegs_pkg::REG_FAST_FORWARD:   cfg_in.fast_forward = csr.data[15:0];
            aegs_pkg::REG_SHUTTER_STEPS:  cfg_in.shutter_steps = csr.data[7:0];
            aegs_pkg::REG_TRIM_ON:        cfg_in.trim_on = csr.data[0];
            aegs_pkg::REG_MAX_EXPOSURE:   cfg_in.max_exposure_us = csr.data[27:0];
            aegs_pkg::REG_MAX_GAIN:       cfg_in.max_gain = csr.data[12:0];
            aegs_pkg::REG_MAX_BRIGHTNESS: cfg_in.max_brightness = csr.data[6:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_mean <= 16'd32768;
         cfg_ff.mean_tolerance <= 16'd3277;
         cfg_ff.fast_forward <= 16'd1024;
         cfg_ff.shutter_steps <= 8'd6;
         cfg_ff.trim_on <= 1'b0;
         cfg_ff.max_exposure_us <= 28'd60000000;
         cfg_ff.max_gain <= 13'd4096;
         cfg_ff.max_brightness <= 7'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ----- src/aegs_div.sv -----
// Shared restoring divider, one quotient bit per cycle, 64-bit dividend by 28-bit divisor.
// Depends on aegs_pkg for the request and status structs.
module aegs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  aegs_pkg::div_req_type req,
   output aegs_pkg::div_rsp_type rsp
);
   logic [63:0] quo_ff, quo_in;
   logic [27:0] rem_ff, rem_in;
   logic [27:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [28:0] trial;
   logic [28:0] diff;
   logic        ge;

   assign trial = {rem_ff, quo_ff[63]};
   assign ge = trial >= {1'b0, dsr_ff};
   assign diff = trial - {1'b0, dsr_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = 28'd0;
         dsr_in = req.divisor;
         cnt_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], ge};
         rem_in = ge ? diff[27:0] : trial[27:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.remainder = rem_ff;
endmodule

// ----- bench/aegs_chk.sv -----
`timescale 1ns / 1ps
// Exposure result checker: predicts each frame's result and compares it with the output.
// Depends on aegs_pkg and aegs_if; watches the request, response and register channels.
module aegs_chk (
   input  logic   clock,
   input  logic   reset,
   aegs_req_if    req_chan,
   aegs_rsp_if    rsp_chan,
   aegs_csr_if    csr_chan,
   output int     fail_count,
   output int     pending
);
   typedef struct packed {
      logic [27:0]        shutter_us;
      logic [12:0]        gain_q88;
      logic [6:0]         brightness_now;
      logic signed [31:0] level_now;
      logic [15:0]        smoothed_mean;
   } exposure_result_type;

   exposure_result_type expected_results[$];

   logic [15:0] cfg_target, cfg_tol, cfg_ff;
   logic [7:0]  cfg_steps;
   logic        cfg_trim;
   logic [27:0] cfg_maxexp;
   logic [12:0] cfg_maxgain;
   logic [6:0]  cfg_maxbright;

   logic [15:0]        hist[aegs_pkg::HIST];
   int                 hist_ptr;
   logic signed [31:0] exp_level;
   logic [12:0]        cur_gain;
   logic [6:0]         cur_bright;
   logic [27:0]        cur_shutter;

   function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // 2^(fq/65536) in Q.30, built by repeated square roots
   function automatic logic [63:0] frac_pow2(input logic [15:0] fq);
      logic [63:0] p, c;
      p = 64'd1 << 30;
      c = sqrt_floor(64'd1 << 61);
      for (int k = 1; k <= 16; k++) begin
         if (fq[16-k]) p = (p * c) >> 30;
         c = sqrt_floor(c << 30);
      end
      return p;
   endfunction

   function automatic exposure_result_type advance_exposure(input logic [15:0] fm);
      exposure_result_type res;
      logic [63:0] wsum, s, s2, maxexp, maxg, rr, sq, x, y, q, g, t, avg, diff;
      logic [63:0] change, fq;
      longint lvl, n, r;
      int idx;
      wsum = 0;
      s = cfg_steps == 0 ? 1 : cfg_steps;
      s2 = s * s;
      maxexp = cfg_maxexp == 0 ? 1 : cfg_maxexp;
      maxg = cfg_maxgain < 256 ? 256 : cfg_maxgain;
      hist[hist_ptr] = fm;
      for (int i = 1; i <= aegs_pkg::HIST; i++) begin
         idx = (hist_ptr + i) % aegs_pkg::HIST;
         wsum += hist[idx] * i;
      end
      avg = (wsum + aegs_pkg::WSUM / 2) / aegs_pkg::WSUM;
      hist_ptr = (hist_ptr + 1) % aegs_pkg::HIST;
      diff = avg > cfg_target ? avg - cfg_target : cfg_target - avg;
      change = 1;
      if (diff > 2 * cfg_tol) begin
         rr = diff * cfg_ff * s;
         if (rr >= (64'd1 << 32)) change = 65535;
         else begin
            sq = (rr * rr) >> 48;
            change = sq > 65535 ? 65535 : (sq < 1 ? 1 : sq);
         end
      end
      lvl = exp_level;
      if (avg + cfg_tol < cfg_target) begin
         if (cfg_trim && cur_bright < cfg_maxbright) cur_bright++;
         else if (cur_gain < maxg || cur_shutter < maxexp) lvl = lvl + longint'(change);
      end
      if (avg > cfg_target + cfg_tol) begin
         if (cur_shutter <= 1) begin
            if (cfg_trim && cur_bright > 0) cur_bright--;
         end else lvl = lvl - longint'(change);
      end
      if (lvl > 64'sd2147483647) lvl = 64'sd2147483647;
      if (lvl < -64'sd2147483648) lvl = -64'sd2147483648;
      exp_level = lvl[31:0];
      n = lvl / longint'(s2);
      r = lvl % longint'(s2);
      if (r < 0) begin
         r += longint'(s2);
         n--;
      end
      fq = (64'(r) << 16) / s2;
      x = frac_pow2(fq[15:0]) * 1000000;
      if (n >= 22) y = 64'd1 << 62;
      else if (22 - n >= 64) y = 0;
      else y = x >> (22 - n);
      q = y / maxexp;
      if (q < 256) q = 256;
      if (q > maxg) q = maxg;
      g = cur_gain;
      if (q > g + 512) g += 512;
      else if (q + 512 < g) g -= 512;
      else g = q;
      cur_gain = g[12:0];
      g = cur_gain == 0 ? 1 : cur_gain;
      t = y / g;
      if (t > maxexp) t = maxexp;
      else if (t < 1) t = 1;
      cur_shutter = t[27:0];
      res.shutter_us = cur_shutter;
      res.gain_q88 = cur_gain;
      res.brightness_now = cur_bright;
      res.level_now = exp_level;
      res.smoothed_mean = avg[15:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      exposure_result_type want;
      if (reset) begin
         cfg_target <= 16'd32768; cfg_tol <= 16'd3277; cfg_ff <= 16'd1024;
         cfg_steps <= 8'd6; cfg_trim <= 1'b0; cfg_maxexp <= 28'd60000000;
         cfg_maxgain <= 13'd4096; cfg_maxbright <= 7'd50;
         for (int i = 0; i < aegs_pkg::HIST; i++) hist[i] = aegs_pkg::RING_RESET;
         hist_ptr = 0;
         exp_level = aegs_pkg::LEVEL_RESET;
         cur_gain = aegs_pkg::GAIN_RESET;
         cur_bright = aegs_pkg::BRIGHT_RESET;
         cur_shutter = aegs_pkg::SHUT_RESET;
         expected_results.delete();
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            case (aegs_pkg::csr_index_type'(csr_chan.index))
               aegs_pkg::REG_TARGET_MEAN:    cfg_target <= csr_chan.data[15:0];
               aegs_pkg::REG_MEAN_TOLERANCE: cfg_tol <= csr_chan.data[15:0];
               aegs_pkg::REG_FAST_FORWARD:   cfg_ff <= csr_chan.data[15:0];
               aegs_pkg::REG_SHUTTER_STEPS:  cfg_steps <= csr_chan.data[7:0];
               aegs_pkg::REG_TRIM_ON:        cfg_trim <= csr_chan.data[0];
               aegs_pkg::REG_MAX_EXPOSURE:   cfg_maxexp <= csr_chan.data;
               aegs_pkg::REG_MAX_GAIN:       cfg_maxgain <= csr_chan.data[12:0];
               aegs_pkg::REG_MAX_BRIGHTNESS: cfg_maxbright <= csr_chan.data[6:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            expected_results.insert(expected_results.size(),
                                    advance_exposure(req_chan.frame_mean));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.shutter_us !== want.shutter_us)
                  report_mismatch("shutter_us", rsp_chan.shutter_us, want.shutter_us);
               if (rsp_chan.gain_q88 !== want.gain_q88)
                  report_mismatch("gain_q88", rsp_chan.gain_q88, want.gain_q88);
               if (rsp_chan.brightness_now !== want.brightness_now)
                  report_mismatch("brightness_now", rsp_chan.brightness_now,
                                  want.brightness_now);
               if (rsp_chan.level_now !== want.level_now)
                  report_mismatch("level_now", rsp_chan.level_now, want.level_now);
               if (rsp_chan.smoothed_mean !== want.smoothed_mean)
                  report_mismatch("smoothed_mean", rsp_chan.smoothed_mean,
                                  want.smoothed_mean);
            end
         end
      end
      pending = expected_results.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Top of the exposure stepper bench: clock, reset, stimulus, idling and verdict.
// Depends on aegs_pkg, aegs_if, aegs_chk and the core RTL.
module tb;
   logic clock, reset;
   int   fail_count, pending, idle_cycles, hold_cycles;
   logic hold_rsp;

   aegs_req_if req_chan ();
   aegs_rsp_if rsp_chan ();
   aegs_csr_if csr_chan ();

   auto_exposure_gain_stepper_core u_top (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   aegs_chk u_chk (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_chan(csr_chan), .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) return 0;
      if (sel < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 600);
   endfunction

   // watchdog: cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response side stalls, with one long hold-off
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < 3000; hold_cycles++) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // valid stays up after the transaction; drain() drops it
   task automatic send_frame(input logic [15:0] fm, input bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.frame_mean <= fm;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // valid stays up after the transaction; apply_setting() drops it
   task automatic write_reg(input aegs_pkg::csr_index_type idx, input logic [27:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // brightness sequence: slow drifts with random content and some noise
   task automatic random_frames(input int count);
      logic [15:0] base;
      base = 16'($urandom);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: base = 16'($urandom);
            1: base = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: base = base + 16'($signed($urandom_range(0, 4000)) - 2000);
         endcase
         send_frame(base, 1'b1);
      end
   endtask

   task automatic apply_setting(input int sel);
      case (sel)
         0: begin
            write_reg(aegs_pkg::REG_TARGET_MEAN, 28'd32768);
            write_reg(aegs_pkg::REG_MEAN_TOLERANCE, 28'd3277);
            write_reg(aegs_pkg::REG_FAST_FORWARD, 28'd1024);
            write_reg(aegs_pkg::REG_SHUTTER_STEPS, 28'd6);
            write_reg(aegs_pkg::REG_TRIM_ON, 28'd1);
            write_reg(aegs_pkg::REG_MAX_EXPOSURE, 28'd60000000);
            write_reg(aegs_pkg::REG_MAX_GAIN, 28'd4096);
            write_reg(aegs_pkg::REG_MAX_BRIGHTNESS, 28'd100);
         end
         1: begin
            write_reg(aegs_pkg::REG_TARGET_MEAN, 28'd0);
            write_reg(aegs_pkg::REG_MEAN_TOLERANCE, 28'd0);
            write_reg(aegs_pkg::REG_FAST_FORWARD, 28'd65535);
            write_reg(aegs_pkg::REG_SHUTTER_STEPS, 28'd255);
            write_reg(aegs_pkg::REG_TRIM_ON, 28'd0);
            write_reg(aegs_pkg::REG_MAX_EXPOSURE, 28'd240000000);
            write_reg(aegs_pkg::REG_MAX_GAIN, 28'd256);
            write_reg(aegs_pkg::REG_MAX_BRIGHTNESS, 28'd0);
         end
         2: begin
            write_reg(aegs_pkg::REG_TARGET_MEAN, 28'd65535);
            write_reg(aegs_pkg::REG_MEAN_TOLERANCE, 28'd65535);
            write_reg(aegs_pkg::REG_FAST_FORWARD, 28'd0);
            write_reg(aegs_pkg::REG_SHUTTER_STEPS, 28'd0);
            write_reg(aegs_pkg::REG_TRIM_ON, 28'd1);
            write_reg(aegs_pkg::REG_MAX_EXPOSURE, 28'd1);
            write_reg(aegs_pkg::REG_MAX_GAIN, 28'd100);
            write_reg(aegs_pkg::REG_MAX_BRIGHTNESS, 28'd127);
         end
         3: begin
            write_reg(aegs_pkg::REG_TARGET_MEAN, 28'd20000);
            write_reg(aegs_pkg::REG_MEAN_TOLERANCE, 28'd500);
            write_reg(aegs_pkg::REG_FAST_FORWARD, 28'd4000);
            write_reg(aegs_pkg::REG_SHUTTER_STEPS, 28'd1);
            write_reg(aegs_pkg::REG_TRIM_ON, 28'd0);
            write_reg(aegs_pkg::REG_MAX_EXPOSURE, 28'd0);
            write_reg(aegs_pkg::REG_MAX_GAIN, 28'd8191);
            write_reg(aegs_pkg::REG_MAX_BRIGHTNESS, 28'd3);
         end
         default: begin
            write_reg(aegs_pkg::REG_TARGET_MEAN, 28'($urandom));
            write_reg(aegs_pkg::REG_MEAN_TOLERANCE, 28'($urandom_range(0, 8000)));
            write_reg(aegs_pkg::REG_FAST_FORWARD, 28'($urandom));
            write_reg(aegs_pkg::REG_SHUTTER_STEPS, 28'($urandom_range(1, 255)));
            write_reg(aegs_pkg::REG_TRIM_ON, 28'($urandom_range(0, 1)));
            write_reg(aegs_pkg::REG_MAX_EXPOSURE, 28'($urandom_range(1000, 240000000)));
            write_reg(aegs_pkg::REG_MAX_GAIN, 28'($urandom_range(256, 4096)));
            write_reg(aegs_pkg::REG_MAX_BRIGHTNESS, 28'($urandom_range(0, 100)));
         end
      endcase
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] directed[] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                                  16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555,
                                  16'hAAAA, 16'h7FFF, 16'h8001, 16'h0001, 16'hFFFE};
      hold_rsp = 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.frame_mean <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= aegs_pkg::REG_TARGET_MEAN;
      csr_chan.data <= '0;
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, extremes of brightness
      foreach (directed[i]) send_frame(directed[i], 1'b0);
      drain();
      apply_setting(1);
      for (int i = 0; i < 5; i++) send_frame(16'hFFFF, 1'b0);
      drain();
      apply_setting(2);
      for (int i = 0; i < 5; i++) send_frame(16'h0000, 1'b0);
      drain();

      apply_setting(0);
      hold_rsp = 1'b1;
      random_frames(120);
      drain();
      apply_setting(3);
      random_frames(100);
      drain();
      for (int p = 0; p < 4; p++) begin
         apply_setting(4);
         random_frames(80);
         // pause until every result is back
         drain();
      end
      apply_setting(0);
      random_frames(90);
      drain();

      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
